// ----- src/lbc_pkg.sv -----
// Shared types and constants for the multi-channel LED blink controller.
package lbc_pkg;

  // Number of LED channels and the width of every countdown and duration.
  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 32;

  // Widths of the fixed item fields.
  localparam int FUNC_BITS   = 2;
  localparam int INDEX_BITS  = 4;
  localparam int DUR_BITS    = 32;
  localparam int STATUS_BITS = 2;
  localparam int LEVEL_BITS  = 4;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_FIELD_BITS  = INDEX_BITS + DUR_BITS + DUR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = STATUS_BITS + LEVEL_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS   = 8;

  // Item kinds carried in tuser.
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ON    = 2'd1,
    FUNC_OFF   = 2'd2,
    FUNC_BLINK = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_t;

  // Per-channel command, already qualified by enable, index and handshake.
  typedef struct packed {
    logic                 tick;
    logic                 turn_on;
    logic                 turn_off;
    logic                 blink;
    logic [TIME_BITS-1:0] on_time;
    logic [TIME_BITS-1:0] off_time;
  } chan_cmd_t;

endpackage

// ----- src/lbc_channel.sv -----
// State and blink countdown of one LED channel.
module lbc_channel (
  input  logic              clk,
  input  logic              rst,
  input  lbc_pkg::chan_cmd_t cmd,
  output logic              pin_next
);

  logic                          pin;
  logic                          phase;
  logic                          active;
  logic [lbc_pkg::TIME_BITS-1:0] ticks;
  logic [lbc_pkg::TIME_BITS-1:0] on_time;
  logic [lbc_pkg::TIME_BITS-1:0] off_time;

  logic                          phase_next;
  logic                          active_next;
  logic [lbc_pkg::TIME_BITS-1:0] ticks_next;
  logic [lbc_pkg::TIME_BITS-1:0] on_time_next;
  logic [lbc_pkg::TIME_BITS-1:0] off_time_next;

  // Next state: on and off stop blinking, blink starts or retunes, a tick counts down.
  // On idle cycles none of the branches applies and everything holds.
  always_comb begin
    pin_next      = pin;
    phase_next    = phase;
    active_next   = active;
    ticks_next    = ticks;
    on_time_next  = on_time;
    off_time_next = off_time;
    if (cmd.turn_on || cmd.turn_off) begin
      active_next = 1'b0;
      pin_next    = cmd.turn_on;
    end else if (cmd.blink) begin
      on_time_next  = cmd.on_time;
      off_time_next = cmd.off_time;
      if (!active) begin
        active_next = 1'b1;
        ticks_next  = lbc_pkg::TIME_BITS'(1);
      end
    end else if (cmd.tick && active) begin
      if (ticks <= lbc_pkg::TIME_BITS'(1)) begin
        pin_next   = ~pin;
        phase_next = ~phase;
        ticks_next = phase_next ? on_time : off_time;
      end else begin
        ticks_next = ticks - lbc_pkg::TIME_BITS'(1);
      end
    end
  end

  // Control bits are cleared at reset; the countdown and durations are loaded before use.
  always_ff @(posedge clk) begin
    if (rst) begin
      pin    <= 1'b0;
      phase  <= 1'b0;
      active <= 1'b0;
    end else begin
      pin    <= pin_next;
      phase  <= phase_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    ticks    <= ticks_next;
    on_time  <= on_time_next;
    off_time <= off_time_next;
  end

endmodule

// ----- src/multi_led_blink_controller.sv -----
// Top level of the multi-channel LED blink controller.
//
// Items arrive on the s_ stream: tuser carries the item kind (tick, turn on,
// turn off, blink) and tdata the channel index and the two blink durations.
// Every accepted item yields exactly one result item on the m_ stream with a
// status and the pin levels of channels 0 to 3 after the item.
// The enable register is written through cfg_valid/cfg_ready/cfg_data and is
// always ready; the user must write it only while no item is in flight, as the
// block does not enforce this. An item is captured in the input register, then
// decoded and applied to its channel (to all channels for a tick) while its
// result is loaded into the output register. One item is taken every cycle
// while the receiver takes results, set by the single decode-and-update stage.
// When the receiver stalls, the result waits in the output register while
// the next item is still captured; s_tready falls only once both registers
// are full. Reset empties both registers, sets the block enabled and turns
// every channel off with blinking stopped.
module multi_led_blink_controller (
  input  logic                               clk,
  input  logic                               rst,
  // Input item stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata, low to high: channel_index[3:0], on_duration[31:0], off_duration[31:0], zero pad.
  input  logic [lbc_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // tuser, low to high: func[1:0], zero pad.
  input  logic [lbc_pkg::IN_USER_BITS-1:0]   s_tuser,
  // Result item stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata, low to high: status[1:0], led_levels[3:0], zero pad.
  output logic [lbc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // Enable register write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);

  // Input register.
  logic                            in_valid;
  lbc_pkg::func_t                  in_func;
  logic [lbc_pkg::INDEX_BITS-1:0]  in_index;
  logic [lbc_pkg::DUR_BITS-1:0]    in_on;
  logic [lbc_pkg::DUR_BITS-1:0]    in_off;

  // Output register.
  logic                            out_valid;
  lbc_pkg::status_t                out_status;
  logic [lbc_pkg::LEVEL_BITS-1:0]  out_levels;

  logic                            block_enabled;
  logic                            fire;
  logic                            index_ok;
  logic                            cmd_ok;
  lbc_pkg::status_t                status;
  logic [lbc_pkg::TIME_BITS-1:0]   on_clamped;
  logic [lbc_pkg::TIME_BITS-1:0]   off_clamped;
  logic [lbc_pkg::CHANNELS-1:0]    pin_next;
  logic [lbc_pkg::LEVEL_BITS-1:0]  levels_next;

  // Handshakes: the stage moves when the output register is free or being drained.
  assign fire      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  // Enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      block_enabled <= cfg_data;
    end
  end

  // Capture an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= lbc_pkg::func_t'(s_tuser[lbc_pkg::FUNC_BITS-1:0]);
      in_index <= s_tdata[lbc_pkg::INDEX_BITS-1:0];
      in_on    <= s_tdata[lbc_pkg::INDEX_BITS +: lbc_pkg::DUR_BITS];
      in_off   <= s_tdata[lbc_pkg::INDEX_BITS + lbc_pkg::DUR_BITS +: lbc_pkg::DUR_BITS];
    end
  end

  // Status: disabled beats a bad index; ticks always report success.
  assign index_ok = {1'b0, in_index} < (lbc_pkg::INDEX_BITS + 1)'(lbc_pkg::CHANNELS);

  always_comb begin
    priority if (in_func == lbc_pkg::FUNC_TICK) begin
      status = lbc_pkg::STATUS_OK;
    end else if (!block_enabled) begin
      status = lbc_pkg::STATUS_NOT_READY;
    end else if (!index_ok) begin
      status = lbc_pkg::STATUS_BAD_INDEX;
    end else begin
      status = lbc_pkg::STATUS_OK;
    end
  end

  assign cmd_ok = fire && block_enabled && index_ok && (in_func != lbc_pkg::FUNC_TICK);

  // Durations are cut to the counter width and a zero becomes one.
  always_comb begin
    on_clamped  = in_on[lbc_pkg::TIME_BITS-1:0];
    off_clamped = in_off[lbc_pkg::TIME_BITS-1:0];
    if (on_clamped == '0) begin
      on_clamped = lbc_pkg::TIME_BITS'(1);
    end
    if (off_clamped == '0) begin
      off_clamped = lbc_pkg::TIME_BITS'(1);
    end
  end

  // One channel instance per LED, each with its own qualified command.
  for (genvar i = 0; i < lbc_pkg::CHANNELS; i++) begin : g_chan
    lbc_pkg::chan_cmd_t cmd;
    logic               sel;

    assign sel          = cmd_ok && (in_index == lbc_pkg::INDEX_BITS'(i));
    assign cmd.tick     = fire && block_enabled && (in_func == lbc_pkg::FUNC_TICK);
    assign cmd.turn_on  = sel && (in_func == lbc_pkg::FUNC_ON);
    assign cmd.turn_off = sel && (in_func == lbc_pkg::FUNC_OFF);
    assign cmd.blink    = sel && (in_func == lbc_pkg::FUNC_BLINK);
    assign cmd.on_time  = on_clamped;
    assign cmd.off_time = off_clamped;

    lbc_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .pin_next (pin_next[i])
    );
  end

  // The level field shows channels 0 to 3; level bits beyond the channel count read zero.
  for (genvar k = 0; k < lbc_pkg::LEVEL_BITS; k++) begin : g_level
    if (k < lbc_pkg::CHANNELS) begin : g_used
      assign levels_next[k] = pin_next[k];
    end else begin : g_unused
      assign levels_next[k] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status;
      out_levels <= levels_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = lbc_pkg::OUT_DATA_BITS'({out_levels, out_status});

endmodule

// ----- src/lbc_checker.sv -----
// Port-level checks for the LED blink controller, bound to the top level.
module lbc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lbc_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

  // Reset leaves no result pending and the input side open.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result or stall present after reset");

  // The input side only stalls while a result is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // A stalled result holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Only defined status codes appear, and the pad bits stay clear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3 &&
      m_tdata[lbc_pkg::OUT_DATA_BITS-1:lbc_pkg::OUT_FIELD_BITS] == '0)
    else $error("undefined status or non-zero pad in result");

endmodule

bind multi_led_blink_controller lbc_checker u_lbc_checker (.*);
